// ===== sv/sender_slot_table_lru_aging_macros.svh =====
// Assertion macros for the sender slot table.
`ifndef SENDER_SLOT_TABLE_LRU_AGING_MACROS_SVH
`define SENDER_SLOT_TABLE_LRU_AGING_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SSTLA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sstla: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define SSTLA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sstla: next-cycle check failed");

`endif

// ===== sv/sstla_pkg.sv =====
// Shared constants, types and codes for the sender slot table.
package sstla_pkg;

    localparam int SLOT_COUNT = 12;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W      = $clog2(SLOT_COUNT + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_BASE  = 1'b1;

    localparam logic [31:0] TIMEOUT_RESET = 32'd600000;
    localparam logic [7:0]  BASE_RESET    = 8'd0;

    localparam logic RES_RELEASE = 1'b0;
    localparam logic RES_ASSIGN  = 1'b1;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_SCAN,
        ST_DECIDE,
        ST_ALLOC
    } t_state;

    // Scan token and running search results, handed from cell to cell.
    typedef struct packed {
        logic              tok;
        logic [POS_W-1:0]  pos;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
        logic              have_old;
        logic [31:0]       old_stamp;
        logic [SLOT_W-1:0] old_idx;
    } t_chain;

    // Current transaction and timeout, seen by every cell.
    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] port;
        logic [31:0] now;
        logic [31:0] timeout;
    } t_bcast;

    typedef struct packed {
        logic hit;
        logic idle;
        logic rel;
    } t_cell_stat;

endpackage

// ===== sv/sender_slot_table_lru_aging.sv =====
// Lookup hit: result registered out in the cycle after the MATCH cycle; busy only in MATCH.
// Miss or tick: a token walks the cell row one slot per cycle through the SCAN state;
// busy through MATCH, SCAN and DECIDE (tick, free slot), plus ALLOC (eviction).
// Releases stream out one per cycle during the walk; assignment comes last.
// Synchronous active-low reset frees every slot and loads default registers.
// Results are shown for one cycle on o_strobe; the receiver cannot stall.
module sender_slot_table_lru_aging
    import sstla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [31:0]           i_sender_ip,
    input  logic [15:0]           i_sender_port,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output logic                  o_result_kind,
    output logic [7:0]            o_origin,
    output logic                  o_last
);

    t_bcast                bcast;
    logic [SLOT_COUNT-1:0] wr_sel;
    t_chain                chain [SLOT_COUNT+1];
    t_cell_stat            stat  [SLOT_COUNT];

    sstla_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_sender_ip   (i_sender_ip),
        .i_sender_port (i_sender_port),
        .i_now_ms      (i_now_ms),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_bcast       (bcast),
        .o_wr_sel      (wr_sel),
        .o_inject      (chain[0]),
        .i_final       (chain[SLOT_COUNT]),
        .i_stat        (stat),
        .o_strobe      (o_strobe),
        .o_result_kind (o_result_kind),
        .o_origin      (o_origin),
        .o_last        (o_last)
    );

    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        sstla_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_chain (chain[g]),
            .o_chain (chain[g+1]),
            .i_bcast (bcast),
            .i_wr    (wr_sel[g]),
            .o_stat  (stat[g])
        );
    end

endmodule

// ===== sv/sstla_cell.sv =====
// One slot of the table: match, idle check and one step of the victim search.
module sstla_cell
    import sstla_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chain     i_chain,
    output t_chain     o_chain,
    input  t_bcast     i_bcast,
    input  logic       i_wr,
    output t_cell_stat o_stat
);

    logic        r_valid;
    logic [31:0] r_ip;
    logic [15:0] r_port;
    logic [31:0] r_stamp;
    t_chain      r_chain;
    t_chain      n_chain;

    logic [31:0] age;
    logic [31:0] stamp_diff;
    logic        idle;
    logic        rel;

    assign age        = i_bcast.now - r_stamp;
    assign idle       = r_valid && (age >= i_bcast.timeout);
    assign rel        = i_chain.tok && idle;
    assign stamp_diff = r_stamp - i_chain.old_stamp;

    always_comb begin
        n_chain     = i_chain;
        n_chain.pos = i_chain.pos + POS_W'(1);
        // Slot freed by this reap step counts as free too.
        if (!i_chain.free_found && (!r_valid || idle)) begin
            n_chain.free_found = 1'b1;
            n_chain.free_idx   = i_chain.pos[SLOT_W-1:0];
        end
        // Strictly older replaces, so the lowest index wins ties.
        if (!i_chain.have_old || stamp_diff[31]) begin
            n_chain.have_old  = 1'b1;
            n_chain.old_stamp = r_stamp;
            n_chain.old_idx   = i_chain.pos[SLOT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_chain <= '0;
        end else begin
            r_chain <= n_chain;
            if (i_wr) begin
                r_valid <= 1'b1;
            end else if (rel) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_ip    <= i_bcast.ip;
            r_port  <= i_bcast.port;
            r_stamp <= i_bcast.now;
        end
    end

    assign o_chain     = r_chain;
    assign o_stat.hit  = r_valid && (r_ip == i_bcast.ip) && (r_port == i_bcast.port);
    assign o_stat.idle = idle;
    assign o_stat.rel  = rel;

endmodule

// ===== sv/sstla_ctrl.sv =====
// Sequencer: takes transactions, drives the cell row and emits results.
`include "sender_slot_table_lru_aging_macros.svh"

module sstla_ctrl
    import sstla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  i_kind,
    input  logic [31:0]           i_sender_ip,
    input  logic [15:0]           i_sender_port,
    input  logic [31:0]           i_now_ms,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_bcast                o_bcast,
    output logic [SLOT_COUNT-1:0] o_wr_sel,
    output t_chain                o_inject,
    input  t_chain                i_final,
    input  t_cell_stat            i_stat [SLOT_COUNT],
    output logic                  o_strobe,
    output logic                  o_result_kind,
    output logic [7:0]            o_origin,
    output logic                  o_last
);

    t_state r_state;
    t_state n_state;

    logic              r_kind;
    logic [31:0]       r_ip;
    logic [15:0]       r_port;
    logic [31:0]       r_now;
    logic [31:0]       r_timeout;
    logic [7:0]        r_origin_base;
    logic [SLOT_W-1:0] r_cnt;
    logic [SLOT_W-1:0] r_target;

    logic              r_strobe;
    logic              r_result_kind;
    logic [7:0]        r_origin;
    logic              r_last;

    logic              n_strobe;
    logic              n_result_kind;
    logic [SLOT_W-1:0] n_slot;
    logic              n_last;
    logic              inject_tok;

    logic [SLOT_COUNT-1:0] hit_vec;
    logic [SLOT_COUNT-1:0] idle_vec;
    logic [SLOT_COUNT-1:0] rel_vec;
    logic [SLOT_COUNT-1:0] above;
    logic [SLOT_W-1:0]     hit_idx;
    logic                  accept;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            hit_vec[i]  = i_stat[i].hit;
            idle_vec[i] = i_stat[i].idle;
            rel_vec[i]  = i_stat[i].rel;
            above[i]    = (SLOT_W'(i) > r_cnt);
        end
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (hit_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if ((r_kind == KIND_LOOKUP) && (|hit_vec)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SLOT_W'(SLOT_COUNT - 1)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if ((r_kind == KIND_TICK) || i_final.free_found) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_ALLOC;
                end
            end
            ST_ALLOC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs toward cells and result port.
    always_comb begin
        n_strobe      = 1'b0;
        n_result_kind = RES_RELEASE;
        n_slot        = '0;
        n_last        = 1'b0;
        o_wr_sel      = '0;
        inject_tok    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
            end
            ST_MATCH: begin
                if ((r_kind == KIND_LOOKUP) && (|hit_vec)) begin
                    o_wr_sel[hit_idx] = 1'b1;
                    n_strobe          = 1'b1;
                    n_result_kind     = RES_ASSIGN;
                    n_slot            = hit_idx;
                    n_last            = 1'b1;
                end
            end
            ST_SCAN: begin
                inject_tok = (r_cnt == '0);
                if (|rel_vec) begin
                    n_strobe = 1'b1;
                    n_slot   = r_cnt;
                    // A lookup always ends with its assignment.
                    n_last   = (r_kind == KIND_TICK) && !(|(idle_vec & above));
                end
            end
            ST_DECIDE: begin
                if (r_kind == KIND_LOOKUP) begin
                    n_strobe = 1'b1;
                    if (i_final.free_found) begin
                        o_wr_sel[i_final.free_idx] = 1'b1;
                        n_result_kind              = RES_ASSIGN;
                        n_slot                     = i_final.free_idx;
                        n_last                     = 1'b1;
                    end else begin
                        n_slot = i_final.old_idx;
                    end
                end
            end
            ST_ALLOC: begin
                o_wr_sel[r_target] = 1'b1;
                n_strobe           = 1'b1;
                n_result_kind      = RES_ASSIGN;
                n_slot             = r_target;
                n_last             = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_strobe      <= 1'b0;
            r_timeout     <= TIMEOUT_RESET;
            r_origin_base <= BASE_RESET;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_IDLE_TIMEOUT: r_timeout     <= i_cfg_data[31:0];
                    CFG_ORIGIN_BASE:  r_origin_base <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_ip   <= i_sender_ip;
            r_port <= i_sender_port;
            r_now  <= i_now_ms;
        end
        if (r_state == ST_MATCH) begin
            r_cnt <= '0;
        end else if (r_state == ST_SCAN) begin
            r_cnt <= r_cnt + SLOT_W'(1);
        end
        if (r_state == ST_DECIDE) begin
            r_target <= i_final.old_idx;
        end
        r_result_kind <= n_result_kind;
        r_origin      <= r_origin_base + 8'(n_slot);
        r_last        <= n_last;
    end

    assign o_bcast.ip      = r_ip;
    assign o_bcast.port    = r_port;
    assign o_bcast.now     = r_now;
    assign o_bcast.timeout = r_timeout;

    always_comb begin
        o_inject     = '0;
        o_inject.tok = inject_tok;
    end

    assign o_strobe      = r_strobe;
    assign o_result_kind = r_result_kind;
    assign o_origin      = r_origin;
    assign o_last        = r_last;

    `SSTLA_ASSERT_NEXT(a_accept_to_match, start && !busy, r_state == ST_MATCH)
    `SSTLA_ASSERT_NOW(a_single_hit, 1'b1, $onehot0(hit_vec))
    `SSTLA_ASSERT_NOW(a_single_write, 1'b1, $onehot0(o_wr_sel))
    `SSTLA_ASSERT_NOW(a_single_release, 1'b1, $onehot0(rel_vec))
    `SSTLA_ASSERT_NOW(a_token_at_end, r_state == ST_DECIDE, i_final.tok)

endmodule
